[rtl/ajt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ajt_pkg
// Shared types and constants for the ancestor jump table builder.
// ----------------------------------------------------------------------------
package ajt_pkg;

    localparam int VALUE_W = 8;
    localparam int LEVEL_W = 4;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIX_RD,
        S_FIX_WR,
        S_BLD_RD1,
        S_BLD_RD2,
        S_BLD_WR,
        S_REP_RD,
        S_REP_CHK,
        S_REP_FIN
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] node;
        logic [LEVEL_W-1:0] level;
        logic [VALUE_W-1:0] ancestor;
        logic               has_ancestor;
        logic               end_of_report;
    } t_res;

endpackage
`default_nettype wire

[rtl/ajt_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ajt_in_if / ajt_out_if
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface ajt_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] value;
    logic       final_parent;

    modport source (output valid, output cmd, output value, output final_parent,
                    input ready);
    modport sink   (input valid, input cmd, input value, input final_parent,
                    output ready);
endinterface

interface ajt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] node;
    logic [3:0] level;
    logic [7:0] ancestor;
    logic       has_ancestor;
    logic       end_of_report;

    modport source (output valid, output node, output level, output ancestor,
                    output has_ancestor, output end_of_report, input ready);
    modport sink   (input valid, input node, input level, input ancestor,
                    input has_ancestor, input end_of_report, output ready);
endinterface
`default_nettype wire

[rtl/ajt_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ajt_mem
// Jump table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ajt_mem
    import ajt_pkg::*;
#(
    parameter int DEPTH = 2304,
    parameter int AW    = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [VALUE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [0:DEPTH-1];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/ajt_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ajt_ctrl
// Sequencer for load, table build and report; shares one range comparator
// and drives the result register.
// ----------------------------------------------------------------------------
module ajt_ctrl
    import ajt_pkg::*;
#(
    parameter int MAX_NODES = 255,
    parameter int LEVELS    = 9,
    parameter int NW        = 8,
    parameter int AW        = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    ajt_in_if.sink                  i_item,
    ajt_out_if.source               o_res,
    output logic                    o_mem_we,
    output logic [AW-1:0]           o_mem_waddr,
    output logic [VALUE_W-1:0]      o_mem_wdata,
    output logic [AW-1:0]           o_mem_raddr,
    input  wire logic [VALUE_W-1:0] i_mem_rdata
);

    localparam int DW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = (NW > VALUE_W) ? NW : VALUE_W;

    function automatic logic [AW-1:0] f_addr(input logic [DW-1:0] d,
                                             input logic [NW-1:0] i);
        return AW'({d, i});
    endfunction

    t_state             r_state, n_state;
    logic [NW-1:0]      r_lc, n_lc;
    logic               r_ready, n_ready;
    logic [NW-1:0]      r_i, n_i;
    logic [DW-1:0]      r_d, n_d;
    logic [VALUE_W-1:0] r_mid, n_mid;
    logic [VALUE_W-1:0] r_node, n_node;
    logic               r_pend_valid, n_pend_valid;
    logic [DW-1:0]      r_pend_level, n_pend_level;
    logic [VALUE_W-1:0] r_pend_anc, n_pend_anc;
    logic               r_out_valid, n_out_valid;
    t_res               r_out, n_out;

    logic [VALUE_W-1:0] cmp_opnd;
    logic               cmp_le;
    logic               out_free;
    logic [DW-1:0]      dm1;

    // shared range comparator against the loaded count
    always_comb begin
        case (r_state)
            S_IDLE:   cmp_opnd = i_item.value;
            S_FIX_WR: cmp_opnd = i_mem_rdata;
            default:  cmp_opnd = r_mid;
        endcase
    end
    assign cmp_le   = (CW'(cmp_opnd) <= CW'(r_lc));
    assign out_free = !r_out_valid || o_res.ready;
    assign dm1      = r_d - DW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_lc         <= '0;
            r_ready      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_lc         <= n_lc;
            r_ready      <= n_ready;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_i          <= n_i;
        r_d          <= n_d;
        r_mid        <= n_mid;
        r_node       <= n_node;
        r_pend_level <= n_pend_level;
        r_pend_anc   <= n_pend_anc;
        r_out        <= n_out;
    end

    always_comb begin
        logic [NW-1:0] lc_eff;
        logic          can_go;

        n_state      = r_state;
        n_lc         = r_lc;
        n_ready      = r_ready;
        n_i          = r_i;
        n_d          = r_d;
        n_mid        = r_mid;
        n_node       = r_node;
        n_pend_valid = r_pend_valid;
        n_pend_level = r_pend_level;
        n_pend_anc   = r_pend_anc;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_res.ready;
        o_mem_we     = 1'b0;
        o_mem_waddr  = '0;
        o_mem_wdata  = '0;
        o_mem_raddr  = f_addr(r_d, r_i);
        lc_eff       = r_ready ? '0 : r_lc;
        can_go       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    if (i_item.cmd == CMD_LOAD) begin
                        n_ready = 1'b0;
                        n_lc    = lc_eff;
                        if (lc_eff < NW'(MAX_NODES)) begin
                            n_lc        = lc_eff + NW'(1);
                            o_mem_we    = 1'b1;
                            o_mem_waddr = f_addr('0, lc_eff + NW'(1));
                            o_mem_wdata = i_item.value;
                        end
                        if (i_item.final_parent) begin
                            n_i     = '0;
                            n_d     = '0;
                            n_state = S_FIX_RD;
                        end
                    end else begin
                        n_node       = i_item.value;
                        n_d          = '0;
                        n_pend_valid = 1'b0;
                        n_i          = NW'(i_item.value);
                        if (r_ready && i_item.value != '0 && cmp_le) begin
                            n_state = S_REP_RD;
                        end else begin
                            n_state = S_REP_FIN;
                        end
                    end
                end
            end
            S_FIX_RD: begin
                o_mem_raddr = f_addr('0, r_i);
                n_state     = S_FIX_WR;
            end
            S_FIX_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = f_addr('0, r_i);
                o_mem_wdata = (r_i == '0 || !cmp_le) ? '0 : i_mem_rdata;
                if (r_i == r_lc) begin
                    n_i = '0;
                    if (LEVELS > 1) begin
                        n_d     = DW'(1);
                        n_state = S_BLD_RD1;
                    end else begin
                        n_ready = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_i     = r_i + NW'(1);
                    n_state = S_FIX_RD;
                end
            end
            S_BLD_RD1: begin
                o_mem_raddr = f_addr(dm1, r_i);
                n_state     = S_BLD_RD2;
            end
            S_BLD_RD2: begin
                n_mid       = i_mem_rdata;
                o_mem_raddr = f_addr(dm1, NW'(i_mem_rdata));
                n_state     = S_BLD_WR;
            end
            S_BLD_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = f_addr(r_d, r_i);
                o_mem_wdata = cmp_le ? i_mem_rdata : '0;
                if (r_i == r_lc) begin
                    n_i = '0;
                    if (r_d == DW'(LEVELS - 1)) begin
                        n_ready = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_d     = r_d + DW'(1);
                        n_state = S_BLD_RD1;
                    end
                end else begin
                    n_i     = r_i + NW'(1);
                    n_state = S_BLD_RD1;
                end
            end
            S_REP_RD: begin
                n_state = S_REP_CHK;
            end
            S_REP_CHK: begin
                // hold the read address so the read data stays put while stalled
                can_go = (i_mem_rdata == '0) || !r_pend_valid || out_free;
                if (can_go) begin
                    if (i_mem_rdata != '0) begin
                        if (r_pend_valid) begin
                            n_out_valid         = 1'b1;
                            n_out.node          = r_node;
                            n_out.level         = LEVEL_W'(r_pend_level);
                            n_out.ancestor      = r_pend_anc;
                            n_out.has_ancestor  = 1'b1;
                            n_out.end_of_report = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_level = r_d;
                        n_pend_anc   = i_mem_rdata;
                    end
                    if (r_d == DW'(LEVELS - 1)) begin
                        n_state = S_REP_FIN;
                    end else begin
                        n_d     = r_d + DW'(1);
                        n_state = S_REP_RD;
                    end
                end
            end
            S_REP_FIN: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.node          = r_node;
                    n_out.level         = r_pend_valid ? LEVEL_W'(r_pend_level) : '0;
                    n_out.ancestor      = r_pend_valid ? r_pend_anc : '0;
                    n_out.has_ancestor  = r_pend_valid;
                    n_out.end_of_report = 1'b1;
                    n_pend_valid        = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_item.ready        = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.node          = r_out.node;
    assign o_res.level         = r_out.level;
    assign o_res.ancestor      = r_out.ancestor;
    assign o_res.has_ancestor  = r_out.has_ancestor;
    assign o_res.end_of_report = r_out.end_of_report;

endmodule
`default_nettype wire

[rtl/ancestor_jump_table_builder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ancestor_jump_table_builder
// Binary lifting ancestor table: loads parents, builds the jump table in
// memory and reports the nonzero ancestors of a node level by level.
// ----------------------------------------------------------------------------
//  channel   dir  fields                                        transaction
//  i_item    in   cmd, value, final_parent                      valid & ready
//  o_res     out  node, level, ancestor, has_ancestor,          valid & ready
//                 end_of_report
//
//  Load: the final load starts the table build, which walks every level over
//  the loaded nodes through the single table memory port pair.
//  Report: reads and checks each level, stalls on output; empty report goes straight to its final result.
//  Synchronous active-low reset clears control state; table is not cleared.
//  i_item.ready is high only in idle; one result register feeds o_res.
// ----------------------------------------------------------------------------
module ancestor_jump_table_builder
    import ajt_pkg::*;
#(
    parameter int MAX_NODES = 255,
    parameter int LEVELS    = 9
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ajt_in_if.sink    i_item,
    ajt_out_if.source o_res
);

    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int DEPTH = LEVELS * (2 ** NW);
    localparam int AW    = $clog2(DEPTH);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    ajt_ctrl #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS),
        .NW        (NW),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_res       (o_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    ajt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire

[rtl/ajt_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ajt_checker
// Port-level checks for the ancestor jump table builder.
// ----------------------------------------------------------------------------
module ajt_checker
    import ajt_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_cmd,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_node,
    input wire logic [3:0] i_out_level,
    input wire logic [7:0] i_out_ancestor,
    input wire logic       i_out_has_ancestor,
    input wire logic       i_out_end_of_report
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_node)
            && $stable(i_out_level) && $stable(i_out_ancestor)
            && $stable(i_out_has_ancestor) && $stable(i_out_end_of_report))
        else $error("result changed while stalled");

    // ready drops right after a report transaction
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_cmd == CMD_REPORT |=> !i_in_ready)
        else $error("ready right after a report transaction");

    // empty report is a single terminal zero result
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_has_ancestor |->
            i_out_end_of_report && i_out_ancestor == 8'd0 && i_out_level == 4'd0)
        else $error("malformed empty report");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_has_ancestor |-> i_out_ancestor != 8'd0)
        else $error("zero ancestor flagged valid");

endmodule

bind ancestor_jump_table_builder ajt_checker u_ajt_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_item.valid),
    .i_in_ready          (i_item.ready),
    .i_in_cmd            (i_item.cmd),
    .i_out_valid         (o_res.valid),
    .i_out_ready         (o_res.ready),
    .i_out_node          (o_res.node),
    .i_out_level         (o_res.level),
    .i_out_ancestor      (o_res.ancestor),
    .i_out_has_ancestor  (o_res.has_ancestor),
    .i_out_end_of_report (o_res.end_of_report)
);
`default_nettype wire

[test/ancestor_jump_table_builder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ancestor_jump_table_builder_test
// Drives parent loads and ancestor reports through the valid/ready channels,
// keeps its own binary lifting table to predict every report transaction and
// checks each result field by field, under random stalls on both sides.
// ----------------------------------------------------------------------------
module ancestor_jump_table_builder_test;
    import ajt_pkg::*;

    localparam int          MAX_NODES   = 255;
    localparam int          LEVELS      = 9;
    localparam int          HOLD_CYCLES = 500;
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ajt_in_if  in_if ();
    ajt_out_if out_if ();

    ancestor_jump_table_builder #(
        .MAX_NODES(MAX_NODES),
        .LEVELS   (LEVELS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (in_if),
        .o_res  (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    bit [7:0]    jump_tab [LEVELS][MAX_NODES+1];
    int unsigned node_cnt;
    bit          tab_built;
    t_res        ancestry_q[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_asks;
    int unsigned hold_taken;
    int unsigned hold_left;
    int unsigned cycle_cnt;
    int unsigned mismatches;

    function automatic void rebuild_jumps();
        int unsigned i;
        int          d;
        bit [7:0]    mid;
        jump_tab[0][0] = '0;
        for (i = 1; i <= node_cnt; i++) begin
            if (jump_tab[0][i] > node_cnt) jump_tab[0][i] = '0;
        end
        for (d = 1; d < LEVELS; d++) begin
            jump_tab[d][0] = '0;
            for (i = 1; i <= node_cnt; i++) begin
                mid = jump_tab[d-1][i];
                jump_tab[d][i] = (mid <= node_cnt) ? jump_tab[d-1][mid] : 8'd0;
            end
        end
        tab_built = 1'b1;
    endfunction

    // Updates the table on a load, queues the expected results on a report.
    function automatic void compute_ancestry(input logic c, input logic [7:0] v,
                                             input logic f);
        t_res r;
        int   d;
        int   last;
        if (c == CMD_LOAD) begin
            if (tab_built) begin
                tab_built = 1'b0;
                node_cnt  = 0;
            end
            if (node_cnt < MAX_NODES) begin
                node_cnt++;
                jump_tab[0][node_cnt] = v;
            end
            if (f) rebuild_jumps();
        end else begin
            last = -1;
            if (tab_built && v >= 1 && v <= node_cnt) begin
                for (d = 0; d < LEVELS; d++) begin
                    if (jump_tab[d][v] != 0) last = d;
                end
            end
            if (last < 0) begin
                r.node          = v;
                r.level         = '0;
                r.ancestor      = '0;
                r.has_ancestor  = 1'b0;
                r.end_of_report = 1'b1;
                ancestry_q.push_back(r);
            end else begin
                for (d = 0; d <= last; d++) begin
                    if (jump_tab[d][v] != 0) begin
                        r.node          = v;
                        r.level         = d[LEVEL_W-1:0];
                        r.ancestor      = jump_tab[d][v];
                        r.has_ancestor  = 1'b1;
                        r.end_of_report = (d == last);
                        ancestry_q.push_back(r);
                    end
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    // valid stays high between back-to-back transactions; it only drops on idle
    task automatic send_item(input logic c, input logic [7:0] v, input logic f);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid        <= 1'b0;
            in_if.value        <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.cmd          <= c;
        in_if.value        <= v;
        in_if.final_parent <= f;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        compute_ancestry(c, v, f);
    endtask

    always @(posedge i_clk) begin
        if (hold_taken != hold_asks) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (ancestry_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result node %0d level %0d anc %0d",
                                          out_if.node, out_if.level, out_if.ancestor));
            end else begin
                want = ancestry_q.pop_front();
                if (out_if.node !== want.node)
                    report_mismatch($sformatf("node %0d, expected %0d",
                                              out_if.node, want.node));
                if (out_if.level !== want.level)
                    report_mismatch($sformatf("node %0d level %0d, expected %0d",
                                              want.node, out_if.level, want.level));
                if (out_if.ancestor !== want.ancestor)
                    report_mismatch($sformatf("node %0d ancestor %0d, expected %0d",
                                              want.node, out_if.ancestor, want.ancestor));
                if (out_if.has_ancestor !== want.has_ancestor)
                    report_mismatch($sformatf("node %0d has_ancestor %0b, expected %0b",
                                              want.node, out_if.has_ancestor,
                                              want.has_ancestor));
                if (out_if.end_of_report !== want.end_of_report)
                    report_mismatch($sformatf("node %0d end_of_report %0b, expected %0b",
                                              want.node, out_if.end_of_report,
                                              want.end_of_report));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_reports_without_table();
        send_item(CMD_REPORT, 8'd255, 1'b0);
        send_item(CMD_REPORT, 8'd0, 1'b1);
    endtask

    task automatic test_chain_lifting();
        int k;
        for (k = 1; k <= 10; k++) send_item(CMD_LOAD, 8'(k - 1), k == 10);
        send_item(CMD_REPORT, 8'd10, 1'b0);
        send_item(CMD_REPORT, 8'd1, 1'b0);
        send_item(CMD_REPORT, 8'd11, 1'b1);
        send_item(CMD_REPORT, 8'd0, 1'b0);
    endtask

    // reload after a build; parent 200 is out of range, node 4 is its own parent
    task automatic test_parent_clamp();
        send_item(CMD_LOAD, 8'd0, 1'b0);
        send_item(CMD_LOAD, 8'd1, 1'b0);
        send_item(CMD_LOAD, 8'd200, 1'b0);
        send_item(CMD_LOAD, 8'd4, 1'b1);
        send_item(CMD_REPORT, 8'd4, 1'b1);
        send_item(CMD_REPORT, 8'd3, 1'b0);
    endtask

    task automatic test_partial_load();
        send_item(CMD_LOAD, 8'd0, 1'b0);
        send_item(CMD_LOAD, 8'd1, 1'b0);
        send_item(CMD_REPORT, 8'd1, 1'b0);
    endtask

    task automatic test_result_backpressure();
        int          k;
        int unsigned saved_idle;
        for (k = 1; k <= 8; k++) send_item(CMD_LOAD, 8'(k - 1), k == 8);
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_asks++;
        for (k = 0; k < 10; k++) send_item(CMD_REPORT, 8'($urandom_range(8, 1)), 1'b0);
        send_idle_pct = saved_idle;
    endtask

    // more loads than table slots, as a chain deep enough to reach level 7
    task automatic test_node_overflow();
        int k;
        if (!tab_built) send_item(CMD_LOAD, 8'd0, 1'b1);
        for (k = 1; k <= 258; k++) begin
            send_item(CMD_LOAD, (k <= MAX_NODES) ? 8'(k - 1) : 8'($urandom_range(255)),
                      k == 258);
        end
        send_item(CMD_REPORT, 8'd255, 1'b0);
        send_item(CMD_REPORT, 8'd254, 1'b1);
        send_item(CMD_REPORT, 8'd129, 1'b0);
        send_item(CMD_REPORT, 8'd1, 1'b0);
        send_item(CMD_REPORT, 8'd0, 1'b1);
    endtask

    task automatic test_random_forests(input int unsigned budget);
        int unsigned sent;
        int unsigned size;
        int unsigned k;
        int unsigned par;
        int unsigned nrep;
        logic        close_load;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(9) == 0) begin
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
                sent++;
            end else begin
                size       = ($urandom_range(7) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(12, 1);
                close_load = ($urandom_range(7) != 0);
                for (k = 1; k <= size; k++) begin
                    case ($urandom_range(9))
                        0:       par = 0;
                        1:       par = $urandom_range(255);
                        2, 3, 4: par = k - 1;
                        default: par = $urandom_range(k - 1);
                    endcase
                    send_item(CMD_LOAD, 8'(par), close_load && (k == size));
                end
                nrep = $urandom_range(6, 2);
                for (k = 0; k < nrep; k++) begin
                    send_item(CMD_REPORT,
                              ($urandom_range(5) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(size + 1)),
                              1'($urandom_range(1)));
                end
                sent += size + nrep;
            end
        end
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.cmd          = CMD_LOAD;
        in_if.value        = '0;
        in_if.final_parent = 1'b0;
        out_if.ready       = 1'b0;
        node_cnt           = 0;
        tab_built          = 1'b0;
        hold_asks          = 0;
        hold_taken         = 0;
        hold_left          = 0;
        cycle_cnt          = 0;
        mismatches         = 0;
        send_idle_pct      = 35;
        recv_idle_pct      = 78;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reports_without_table();
        test_chain_lifting();
        test_parent_clamp();
        test_partial_load();
        test_random_forests(55);

        send_idle_pct = 78;
        recv_idle_pct = 35;
        test_result_backpressure();
        test_random_forests(55);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_node_overflow();
        test_random_forests(55);

        in_if.valid <= 1'b0;
        while (ancestry_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
